[src/utf8cd_pkg.sv]
// utf8cd_pkg: shared types and constants of the UTF-8 code point decoder.
// No dependencies; used by utf8_codepoint_decoder.
package utf8cd_pkg;

	localparam int unsigned CpW      = 21;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned HoldN    = 3;
	localparam int unsigned ResN     = 4;
	localparam int unsigned ResCntW  = 3;

	localparam logic [7:0] LeadMask2 = 8'h1F;
	localparam logic [7:0] LeadMask3 = 8'h0F;
	localparam logic [7:0] LeadMask4 = 8'h07;
	localparam logic [7:0] ContMask  = 8'h3F;

	typedef struct packed {
		logic [CpW-1:0] cp;
		logic           fb;
	} res_t;

endpackage

[src/utf8_codepoint_decoder.sv]
// utf8_codepoint_decoder: streaming UTF-8 byte to code point decoder.
// Depends on utf8cd_pkg for result type and masks.
//
// One byte enters per item through an input register; the decode logic
// then fills a four-entry result register in one pass and the results
// leave one per cycle while out_ready is high, head first. A byte with
// at most one result passes from the input register to the result
// register, so plain text sustains one item per cycle while out_ready is
// high. A byte that releases an unfinished sequence yields up to four
// results; the next byte waits in the input register until they have
// left through the single output port. last_in_run marks the final result
// of each item; a held byte, or a terminator with nothing held, yields none.
module utf8_codepoint_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [20:0] code_point,
	output logic        raw_fallback,
	output logic        last_in_run
);

	logic                                  valid_s1;
	logic [utf8cd_pkg::ByteW-1:0]          data_s1;
	logic [utf8cd_pkg::ByteW-1:0]          held_q [utf8cd_pkg::HoldN];
	logic [1:0]                            held_cnt_q;
	logic [1:0]                            need_q;
	utf8cd_pkg::res_t                      ent_q  [utf8cd_pkg::ResN];
	logic [utf8cd_pkg::ResCntW-1:0]        cnt_q;

	utf8cd_pkg::res_t                      res    [utf8cd_pkg::ResN];
	logic [utf8cd_pkg::ResCntW-1:0]        res_n;
	logic [1:0]                            held_cnt_d;
	logic [1:0]                            need_d;
	logic                                  hold_we;
	logic [1:0]                            hold_idx;
	logic [utf8cd_pkg::CpW-1:0]            dec_cp;
	logic                                  is_cont;
	logic                                  pop;
	logic                                  proc;

	assign out_valid    = (cnt_q != '0);
	assign pop          = out_valid && out_ready;
	assign proc         = valid_s1 && ((cnt_q == '0) || ((cnt_q == 3'd1) && out_ready));
	assign in_ready     = !valid_s1 || proc;
	assign code_point   = ent_q[0].cp;
	assign raw_fallback = ent_q[0].fb;
	assign last_in_run  = (cnt_q == 3'd1);

	assign is_cont = (data_s1[7:6] == 2'b10);

	always_comb begin
		case (held_cnt_q)
			2'd1: dec_cp = {10'd0, held_q[0][4:0], data_s1[5:0]};
			2'd2: dec_cp = {5'd0, held_q[0][3:0], held_q[1][5:0], data_s1[5:0]};
			2'd3: dec_cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], data_s1[5:0]};
			default: dec_cp = '0;
		endcase
	end

	always_comb begin
		held_cnt_d = held_cnt_q;
		need_d     = need_q;
		hold_we    = 1'b0;
		hold_idx   = '0;
		res_n      = '0;
		for (int k = 0; k < utf8cd_pkg::ResN; k++) begin
			res[k] = '{cp: '0, fb: 1'b0};
		end
		if ((held_cnt_q != 2'd0) && is_cont) begin
			if (need_q <= 2'd1) begin
				res[0]     = '{cp: dec_cp, fb: 1'b0};
				res_n      = 3'd1;
				held_cnt_d = '0;
				need_d     = '0;
			end else begin
				hold_we    = 1'b1;
				hold_idx   = held_cnt_q;
				held_cnt_d = 2'(held_cnt_q + 2'd1);
				need_d     = 2'(need_q - 2'd1);
			end
		end else begin
			for (int i = 0; i < utf8cd_pkg::HoldN; i++) begin
				if (2'(i) < held_cnt_q) begin
					res[i] = '{cp: {13'd0, held_q[i]}, fb: 1'b1};
				end
			end
			res_n      = {1'b0, held_cnt_q};
			held_cnt_d = '0;
			need_d     = '0;
			if (data_s1 == 8'h00) begin
				res_n = {1'b0, held_cnt_q};
			end else if (!data_s1[7]) begin
				res[held_cnt_q] = '{cp: {13'd0, data_s1}, fb: 1'b0};
				res_n           = 3'({1'b0, held_cnt_q} + 3'd1);
			end else if (data_s1 inside {[8'hC0:8'hDF]}) begin
				hold_we    = 1'b1;
				held_cnt_d = 2'd1;
				need_d     = 2'd1;
			end else if (data_s1 inside {[8'hE0:8'hEF]}) begin
				hold_we    = 1'b1;
				held_cnt_d = 2'd1;
				need_d     = 2'd2;
			end else if (data_s1 inside {[8'hF0:8'hF7]}) begin
				hold_we    = 1'b1;
				held_cnt_d = 2'd1;
				need_d     = 2'd3;
			end else begin
				res[held_cnt_q] = '{cp: {13'd0, data_s1}, fb: 1'b1};
				res_n           = 3'({1'b0, held_cnt_q} + 3'd1);
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= '0;
			need_q     <= '0;
		end else if (proc) begin
			held_cnt_q <= held_cnt_d;
			need_q     <= need_d;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && hold_we) begin
			held_q[hold_idx] <= data_s1;
		end
	end

	// result register: load on a processed item, else shift out on a take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (proc) begin
			cnt_q <= res_n;
		end else if (pop) begin
			cnt_q <= 3'(cnt_q - 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			for (int k = 0; k < utf8cd_pkg::ResN; k++) begin
				ent_q[k] <= res[k];
			end
		end else if (pop) begin
			for (int k = 0; k < utf8cd_pkg::ResN - 1; k++) begin
				ent_q[k] <= ent_q[k+1];
			end
		end
	end

endmodule

[sim/tb_top.sv]
// tb_top: self-checking testbench for utf8_codepoint_decoder, one byte per input item.
// Predicts code points in a small scoreboard class; depends on utf8cd_pkg and the RTL.
// Directed byte sequences are followed by random sequences, with random stalls on both sides.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned RandItems  = 185;
	localparam int unsigned DirN       = 29;

	typedef struct packed {
		logic [utf8cd_pkg::CpW-1:0] cp;
		logic                       fb;
		logic                       last;
	} point_t;

	class code_point_board;
		logic [7:0]  held [utf8cd_pkg::HoldN];
		int unsigned held_n;
		int unsigned need_n;
		point_t      expected_points [$];
		int unsigned n_errors;
		int unsigned n_checked;

		function int unsigned pending();
			return expected_points.size();
		endfunction

		function void note_byte(logic [7:0] b);
			logic [utf8cd_pkg::CpW-1:0] cp;
			point_t                     run [$];
			bit                         taken;
			taken = 1'b0;
			if (held_n > 0) begin
				if (b[7:6] == 2'b10) begin
					taken = 1'b1;
					if (need_n <= 1) begin
						case (held_n)
							1:       cp = utf8cd_pkg::CpW'(held[0] & utf8cd_pkg::LeadMask2);
							2:       cp = utf8cd_pkg::CpW'(held[0] & utf8cd_pkg::LeadMask3);
							default: cp = utf8cd_pkg::CpW'(held[0] & utf8cd_pkg::LeadMask4);
						endcase
						for (int i = 1; i < held_n; i++)
							cp = (cp << 6) | utf8cd_pkg::CpW'(held[i] & utf8cd_pkg::ContMask);
						cp = (cp << 6) | utf8cd_pkg::CpW'(b & utf8cd_pkg::ContMask);
						run.push_back('{cp: cp, fb: 1'b0, last: 1'b0});
						held_n = 0;
						need_n = 0;
					end else begin
						if (held_n < utf8cd_pkg::HoldN) begin
							held[held_n] = b;
							held_n++;
						end
						need_n--;
					end
				end else begin
					for (int i = 0; i < held_n; i++)
						run.push_back('{cp: utf8cd_pkg::CpW'(held[i]), fb: 1'b1, last: 1'b0});
					held_n = 0;
					need_n = 0;
				end
			end
			if (!taken) begin
				if (b == 8'h00) begin
				end else if (b < 8'h80) begin
					run.push_back('{cp: utf8cd_pkg::CpW'(b), fb: 1'b0, last: 1'b0});
				end else if (b[7:5] == 3'b110) begin
					held[0] = b;
					held_n = 1;
					need_n = 1;
				end else if (b[7:4] == 4'b1110) begin
					held[0] = b;
					held_n = 1;
					need_n = 2;
				end else if (b[7:3] == 5'b11110) begin
					held[0] = b;
					held_n = 1;
					need_n = 3;
				end else begin
					run.push_back('{cp: utf8cd_pkg::CpW'(b), fb: 1'b1, last: 1'b0});
				end
			end
			if (run.size() > 0)
				run[run.size()-1].last = 1'b1;
			foreach (run[i])
				expected_points.push_back(run[i]);
		endfunction

		function void check_point(logic [utf8cd_pkg::CpW-1:0] cp, logic fb, logic last);
			point_t want;
			n_checked++;
			if (expected_points.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result: code_point %h raw_fallback %b last_in_run %b",
						cp, fb, last);
			end else begin
				want = expected_points.pop_front();
				if (cp !== want.cp || fb !== want.fb || last !== want.last) begin
					n_errors++;
					if (n_errors <= 10)
						$display({"mismatch on result %0d: code_point %h/%h ",
							"raw_fallback %b/%b last_in_run %b/%b (expected/actual)"},
							n_checked, want.cp, cp, want.fb, fb, want.last, last);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [20:0] code_point;
	logic        raw_fallback;
	logic        last_in_run;

	code_point_board board = new;
	int unsigned     n_cycles = 0;
	int unsigned     n_sent = 0;
	int unsigned     quiet_left = 0;
	bit              sink_hold_done = 1'b0;

	logic [7:0] directed_bytes [DirN] = '{
		8'h01, 8'h7F, 8'h00,
		8'hE2, 8'h82, 8'hAC,
		8'hF0, 8'h9F, 8'h98, 8'h80,
		8'hF7, 8'hBF, 8'hBF, 8'hBF,
		8'hC0, 8'h80,
		8'hBF, 8'hF8, 8'hFF,
		8'hE2, 8'h82, 8'h41,
		8'hF0, 8'h9F, 8'h98, 8'hC3, 8'hA9,
		8'hE2, 8'h00
	};

	utf8_codepoint_decoder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_point  (code_point),
		.raw_fallback(raw_fallback),
		.last_in_run (last_in_run)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles >= CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_point(code_point, raw_fallback, last_in_run);
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] lead_byte(int unsigned len);
		case (len)
			2:       return 8'hC0 | 8'($urandom_range(0, 31));
			3:       return 8'hE0 | 8'($urandom_range(0, 15));
			default: return 8'hF0 | 8'($urandom_range(0, 7));
		endcase
	endfunction

	// hold the item until taken, then idle for a random gap unless a quiet run is active
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_byte(b);
		n_sent++;
		if (quiet_left > 0) begin
			gap = 0;
			quiet_left--;
		end else begin
			gap = pick_gap();
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_sequence(input int unsigned len, input int unsigned n_cont);
		send_byte(lead_byte(len));
		repeat (n_cont) send_byte(cont_byte());
	endtask

	task automatic idle_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!sink_hold_done && board.n_checked >= 60) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				sink_hold_done = 1'b1;
			end else if ($urandom_range(0, 15) == 0) begin
				out_ready <= 1'b1;
				repeat (30) @(posedge clk);
			end else begin
				int unsigned stall;
				stall = pick_gap();
				if (stall == 0) begin
					out_ready <= 1'b1;
					@(posedge clk);
				end else begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int unsigned r;
		int unsigned len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);
		idle_until_drained();

		while (n_sent < DirN + RandItems) begin
			if (n_sent > DirN + RandItems / 2 && n_sent < DirN + RandItems / 2 + 4)
				idle_until_drained();
			if ($urandom_range(0, 19) == 0)
				quiet_left = $urandom_range(10, 30);
			r = $urandom_range(0, 99);
			len = $urandom_range(2, 4);
			if (r < 30)
				send_byte(8'($urandom_range(1, 127)));
			else if (r < 45)
				send_sequence(2, 1);
			else if (r < 58)
				send_sequence(3, 2);
			else if (r < 70)
				send_sequence(4, 3);
			else if (r < 82)
				send_sequence(len, $urandom_range(0, len - 2));
			else if (r < 88)
				send_byte(cont_byte());
			else if (r < 92)
				send_byte(8'($urandom_range(8'hF8, 8'hFF)));
			else if (r < 95)
				send_byte(8'h00);
			else
				send_byte(8'($urandom_range(0, 255)));
		end

		idle_until_drained();
		repeat (20) @(posedge clk);
		if (board.n_errors == 0 && board.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
